[sv/ukt_pkg.sv]
package ukt_pkg;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int POS_W  = 5;
    localparam int FILL_W = 6;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_DUMP   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

endpackage

[sv/ukt_store.sv]
module ukt_store
    import ukt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/unordered_keyed_table_unit.sv]
// Unordered keyed table with linear search, one stored entry visited per cycle.
// Command channel: i_start with i_func, i_entry_key and i_entry_payload is taken
// at an edge where o_busy is low; o_busy then stays high until the command is done.
// Results appear for one cycle each, marked by o_strobe; o_last flags the final beat
// of a command. The receiver cannot stall, so results are never held back.
// Insert: one result, strobed from the insert state that follows the accept.
// Lookup: a match strobes once the scan has read the matching entry; a miss on
// N entries strobes after all N are read, or with no read at all on an empty table.
// Remove: the result comes like a lookup; o_busy stays high after the beat while
// the hole is filled. With remove_mode 0 the last entry is copied into the hole;
// with remove_mode 1 the entries above it shift down, none if it was the last.
// Dump: N beats back to back, one per entry in position order; an
// empty table gives a single beat with status empty.
// The single memory read port, one entry per cycle, sets the scan rate.
// remove_mode is written through i_cfg_valid / o_cfg_ready / i_cfg_data while idle.
// Reset empties the table and clears remove_mode; no clearing pass is needed,
// since only entries below the fill count are ever read.
module unordered_keyed_table_unit
    import ukt_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [1:0]              i_func,
    input  logic signed [KEY_W-1:0] i_entry_key,
    input  logic [PAY_W-1:0]        i_entry_payload,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_data,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [POS_W-1:0]        o_position,
    output logic signed [KEY_W-1:0] o_found_key,
    output logic [PAY_W-1:0]        o_found_payload,
    output logic [FILL_W-1:0]       o_fill_count,
    output logic                    o_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_MOVE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_func, n_func;
    logic [KEY_W-1:0] r_key, n_key;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic [CW-1:0]    r_count, n_count;
    logic             r_mode, n_mode;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_rd_vld, n_rd_vld;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic [IW-1:0]    r_pos, n_pos;

    logic             r_strobe, n_strobe;
    logic [1:0]       r_status, n_status;
    logic [IW-1:0]    r_position, n_position;
    t_entry           r_found, n_found;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_last, n_last;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;
    t_entry           rd_data;
    logic             key_hit;
    logic             dump_end;

    logic [IW+POS_W-1:0]  pos_ext;
    logic [CW+FILL_W-1:0] fill_ext;

    ukt_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (r_addr[IW-1:0]),
        .o_rd_data (rd_data)
    );

    assign key_hit  = (rd_data.key == r_key);
    assign dump_end = ((CW'(r_rd_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_key      = r_key;
        n_pay      = r_pay;
        n_count    = r_count;
        n_mode     = r_mode;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_addr[IW-1:0];
        n_pos      = r_pos;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_position = r_position;
        n_found    = r_found;
        n_fill     = r_fill;
        n_last     = r_last;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = rd_data;
        mem_re     = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_mode = i_cfg_data;
        end

        if ((r_state == S_SCAN || r_state == S_MOVE) && r_addr < r_count) begin
            mem_re   = 1'b1;
            n_rd_vld = 1'b1;
            n_addr   = r_addr + CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func  = i_func;
                    n_key   = $unsigned(i_entry_key);
                    n_pay   = i_entry_payload;
                    n_addr  = '0;
                    n_state = (i_func == FUNC_INSERT) ? S_INS : S_SCAN;
                end
            end
            S_INS: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_state  = S_IDLE;
                if (r_count < CW'(CAPACITY)) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_count[IW-1:0];
                    mem_wdata.key   = r_key;
                    mem_wdata.payload = r_pay;
                    n_status        = ST_OK;
                    n_position      = r_count[IW-1:0];
                    n_found.key     = r_key;
                    n_found.payload = r_pay;
                    n_count         = r_count + CW'(1);
                    n_fill          = r_count + CW'(1);
                end else begin
                    n_status   = ST_FULL;
                    n_position = '0;
                    n_found    = '0;
                    n_fill     = r_count;
                end
            end
            S_SCAN: begin
                if (r_rd_vld) begin
                    if (r_func == FUNC_DUMP) begin
                        n_strobe   = 1'b1;
                        n_status   = ST_OK;
                        n_position = r_rd_idx;
                        n_found    = rd_data;
                        n_fill     = r_count;
                        n_last     = dump_end;
                        if (dump_end) begin
                            n_state  = S_IDLE;
                            n_rd_vld = 1'b0;
                        end
                    end else if (key_hit) begin
                        n_strobe   = 1'b1;
                        n_status   = ST_OK;
                        n_position = r_rd_idx;
                        n_found    = rd_data;
                        n_last     = 1'b1;
                        n_rd_vld   = 1'b0;
                        if (r_func == FUNC_LOOKUP) begin
                            n_fill  = r_count;
                            n_state = S_IDLE;
                        end else begin
                            n_fill  = r_count - CW'(1);
                            n_pos   = r_rd_idx;
                            n_addr  = r_mode ? (CW'(r_rd_idx) + CW'(1)) : (r_count - CW'(1));
                            n_state = S_MOVE;
                        end
                    end
                end else if (r_addr == r_count) begin
                    n_strobe   = 1'b1;
                    n_status   = (r_func == FUNC_DUMP) ? ST_EMPTY : ST_NOTFOUND;
                    n_position = '0;
                    n_found    = '0;
                    n_fill     = r_count;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MOVE: begin
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_mode ? (r_rd_idx - IW'(1)) : r_pos;
                end else if (r_addr >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mode   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mode   <= n_mode;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_position <= n_position;
        r_found    <= n_found;
        r_fill     <= n_fill;
        r_last     <= n_last;
    end

    assign pos_ext  = {{POS_W{1'b0}}, r_position};
    assign fill_ext = {{FILL_W{1'b0}}, r_fill};

    assign o_busy          = (r_state != S_IDLE);
    assign o_cfg_ready     = !o_busy;
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_position      = pos_ext[POS_W-1:0];
    assign o_found_key     = $signed(r_found.key);
    assign o_found_payload = r_found.payload;
    assign o_fill_count    = fill_ext[FILL_W-1:0];
    assign o_last          = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !r_rd_vld)
        else $error("read pending while idle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full reported on a table with room");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("command accepted without going busy");

    a_move_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (r_count != '0))
        else $error("entry move on an empty table");

endmodule
